FILE: hw/rtl/lru_key_value_cache_core_macros.svh
// Assertion macros used by the cache store RTL (lkvc_store).
// Define ASSERT_OFF to compile every assertion away.
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define LKVC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lkvc assertion failed");
`define LKVC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lkvc implication failed");
`else
`define LKVC_ASSERT(lbl, clk, rst_n, prop)
`define LKVC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/lkvc_pkg.sv
// Shared constants and types of the LRU key/value cache.
// No dependencies.
package lkvc_pkg;

  localparam int KEY_W       = 32;
  localparam int VAL_W       = 31;
  localparam int CAP_W       = 5;
  localparam int DEF_ENTRIES = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic put;
    logic hit;
    logic evict;
    logic insert;
  } lkvc_ctrl_t;

endpackage

FILE: hw/rtl/lkvc_lookup.sv
// Match, victim and free-slot decision for one registered request.
// Depends on lkvc_pkg.
module lkvc_lookup
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES,
  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
  input  logic                             req_valid,
  input  logic                             req_put,
  input  logic [KEY_W-1:0]                 req_key,
  input  logic [CAP_W-1:0]                 cap,
  input  logic [ENTRIES-1:0]               ent_valid,
  input  logic [ENTRIES-1:0][KEY_W-1:0]    ent_keys,
  input  logic [ENTRIES-1:0][VAL_W-1:0]    ent_values,
  input  logic [ENTRIES-1:0][RANK_W-1:0]   ent_ranks,
  input  logic [CNT_W-1:0]                 valid_count,
  output lkvc_ctrl_t                       ctrl,
  output logic [ENTRIES-1:0]               slot_oh,
  output logic [RANK_W-1:0]                thr,
  output logic [VAL_W-1:0]                 read_value
);

  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] victim_vec;
  logic [ENTRIES-1:0] free_oh;
  logic [RANK_W-1:0]  last_rank;
  logic [CMP_W-1:0]   cap_ext;
  logic [CMP_W-1:0]   eff_cap;
  logic               any_hit;
  logic               full;
  logic [VAL_W-1:0]   hit_value;

  assign last_rank = RANK_W'(valid_count - CNT_W'(1));

  always_comb begin
    cap_ext = CMP_W'(cap);
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end
  end

  assign full = (CMP_W'(valid_count) >= eff_cap);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]    = ent_valid[i] && (ent_keys[i] == req_key);
      victim_vec[i] = ent_valid[i] && (ent_ranks[i] == last_rank);
    end
  end

  // lowest clear bit of the valid vector
  assign free_oh = ~ent_valid & (ent_valid + ENTRIES'(1));
  assign any_hit = |hit_vec;
  assign slot_oh = any_hit ? hit_vec : (full ? victim_vec : free_oh);

  always_comb begin
    thr       = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_oh[i]) begin
        thr = thr | ent_ranks[i];
      end
      if (hit_vec[i]) begin
        hit_value = hit_value | ent_values[i];
      end
    end
  end

  always_comb begin
    ctrl.put    = req_put;
    ctrl.hit    = req_valid && any_hit;
    ctrl.evict  = req_valid && (req_put == OP_PUT) && !any_hit && full;
    ctrl.insert = req_valid && (req_put == OP_PUT) && !any_hit && !full;
  end

  assign read_value = (any_hit && (req_put == OP_GET)) ? hit_value : '0;

endmodule

FILE: hw/rtl/lkvc_store.sv
// Entry storage: keys, values, valid bits, recency ranks and fill count.
// Depends on lkvc_pkg and lru_key_value_cache_core_macros.svh.
`include "lru_key_value_cache_core_macros.svh"
module lkvc_store
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES,
  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lkvc_ctrl_t                       ctrl,
  input  logic [ENTRIES-1:0]               slot_oh,
  input  logic [RANK_W-1:0]                thr,
  input  logic [KEY_W-1:0]                 wr_key,
  input  logic [VAL_W-1:0]                 wr_value,
  output logic [ENTRIES-1:0]               ent_valid,
  output logic [ENTRIES-1:0][KEY_W-1:0]    ent_keys,
  output logic [ENTRIES-1:0][VAL_W-1:0]    ent_values,
  output logic [ENTRIES-1:0][RANK_W-1:0]   ent_ranks,
  output logic [CNT_W-1:0]                 valid_count
);

  logic [ENTRIES-1:0]             valid_r, valid_nxt;
  logic [ENTRIES-1:0][RANK_W-1:0] rank_r, rank_nxt;
  logic [CNT_W-1:0]               vc_r, vc_nxt;
  logic [ENTRIES-1:0][KEY_W-1:0]  keys_r;
  logic [ENTRIES-1:0][VAL_W-1:0]  vals_r;
  logic                           touch;

  assign touch = ctrl.hit || ctrl.evict || ctrl.insert;

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    vc_nxt    = vc_r;
    if (touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_oh[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (ctrl.insert || (rank_r[i] < thr))) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end
    end
    if (ctrl.insert) begin
      valid_nxt = valid_r | slot_oh;
      vc_nxt    = vc_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rank_r  <= '0;
      vc_r    <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      vc_r    <= vc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_oh[i]) begin
        if (ctrl.evict || ctrl.insert) begin
          keys_r[i] <= wr_key;
        end
        if (ctrl.put && touch) begin
          vals_r[i] <= wr_value;
        end
      end
    end
  end

  assign ent_valid   = valid_r;
  assign ent_keys    = keys_r;
  assign ent_values  = vals_r;
  assign ent_ranks   = rank_r;
  assign valid_count = vc_r;

  `LKVC_ASSERT(a_count_matches, clk, rst_n, ($countones(valid_r) == vc_r))
  `LKVC_ASSERT_IMPLY(a_slot_onehot, clk, rst_n, touch, $onehot(slot_oh))
  `LKVC_ASSERT_IMPLY(a_insert_room, clk, rst_n, ctrl.insert, (vc_r < CNT_W'(ENTRIES)))
  `LKVC_ASSERT(a_insert_grows, clk, rst_n, (ctrl.insert |=> (vc_r == $past(vc_r) + CNT_W'(1))))

endmodule

FILE: hw/rtl/lru_key_value_cache_core.sv
// LRU key/value cache: a request goes from start through the input register,
// then lookup and store update into the result register, which drives out_strobe.
// Throughput is one word per cycle; busy never asserts and results cannot stall.
// Each store update lands in the entry flops that the next lookup reads.
// Synchronous reset clears valid bits, ranks and count at once (no clearing pass)
// and sets the capacity register cap_r to 16.
module lru_key_value_cache_core
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_opcode,
  input  logic signed [KEY_W-1:0] in_lookup_key,
  input  logic [VAL_W-1:0]        in_write_value,
  output logic                    out_strobe,
  output logic                    out_hit,
  output logic [VAL_W-1:0]        out_read_value,
  output logic                    out_evicted,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CAP_W-1:0]        cfg_data
);

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  logic                           req_valid_r;
  logic                           req_op_r;
  logic [KEY_W-1:0]               req_key_r;
  logic [VAL_W-1:0]               req_val_r;
  logic [CAP_W-1:0]               cap_r;
  logic                           res_strobe_r;
  logic                           res_hit_r;
  logic [VAL_W-1:0]               res_value_r;
  logic                           res_evicted_r;

  lkvc_ctrl_t                     ctrl;
  logic [ENTRIES-1:0]             slot_oh;
  logic [RANK_W-1:0]              thr;
  logic [VAL_W-1:0]               read_value;
  logic [ENTRIES-1:0]             ent_valid;
  logic [ENTRIES-1:0][KEY_W-1:0]  ent_keys;
  logic [ENTRIES-1:0][VAL_W-1:0]  ent_values;
  logic [ENTRIES-1:0][RANK_W-1:0] ent_ranks;
  logic [CNT_W-1:0]               valid_count;
  logic                           accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op_r  <= in_opcode;
      req_key_r <= in_lookup_key;
      req_val_r <= in_write_value;
    end
  end

  lkvc_lookup #(
    .ENTRIES (ENTRIES)
  ) u_lookup (
    .req_valid   (req_valid_r),
    .req_put     (req_op_r),
    .req_key     (req_key_r),
    .cap         (cap_r),
    .ent_valid   (ent_valid),
    .ent_keys    (ent_keys),
    .ent_values  (ent_values),
    .ent_ranks   (ent_ranks),
    .valid_count (valid_count),
    .ctrl        (ctrl),
    .slot_oh     (slot_oh),
    .thr         (thr),
    .read_value  (read_value)
  );

  lkvc_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .slot_oh     (slot_oh),
    .thr         (thr),
    .wr_key      (req_key_r),
    .wr_value    (req_val_r),
    .ent_valid   (ent_valid),
    .ent_keys    (ent_keys),
    .ent_values  (ent_values),
    .ent_ranks   (ent_ranks),
    .valid_count (valid_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_strobe_r <= 1'b0;
    end else begin
      res_strobe_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    res_hit_r     <= ctrl.hit;
    res_value_r   <= read_value;
    res_evicted_r <= ctrl.evict;
  end

  assign out_strobe     = res_strobe_r;
  assign out_hit        = res_hit_r;
  assign out_read_value = res_value_r;
  assign out_evicted    = res_evicted_r;

endmodule
